/* design/svt_pkg.sv */
// Package for the sorted value table: sizes, command and result types,
// operation and status codes, and the control bundle that drives the cell chain.
// Used by svt_cell and sorted_value_table; depends on nothing else.
package svt_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = 32;
    localparam logic [KEY_W-1:0] SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_FIND   = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } t_state;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] count;
    } t_result;

    typedef struct packed {
        logic load;
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

/* design/svt_cell.sv */
// One cell of the sorted chain: holds one entry and its compare flags.
// Hands its entry to both neighbors for shifting; depends on svt_pkg.
module svt_cell
    import svt_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic             i_occ,
    input  logic [KEY_W-1:0] i_key,
    input  logic             i_prev_lt,
    input  logic [KEY_W-1:0] i_prev_entry,
    input  logic [KEY_W-1:0] i_next_entry,
    output logic             o_lt,
    output logic             o_hit,
    output logic [KEY_W-1:0] o_entry
);

    logic [KEY_W-1:0] r_entry;
    logic [KEY_W-1:0] n_entry;
    logic             r_lt;
    logic             r_eq;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_lt <= i_occ && (r_entry < i_key);
            r_eq <= i_occ && (r_entry == i_key);
        end
        r_entry <= n_entry;
    end

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && !r_lt) begin
            n_entry = i_prev_lt ? i_key : i_prev_entry;
        end else if (i_ctl.rem && !r_lt) begin
            n_entry = i_next_entry;
        end
    end

    assign o_lt    = r_lt;
    assign o_hit   = r_eq && i_prev_lt;
    assign o_entry = r_entry;

endmodule

/* design/sorted_value_table.sv */
// Top level of the sorted value table: control sequencer and the chain of cells.
// Depends on svt_pkg and svt_cell.
//
// Usage: drive i_cmd and raise start; the command is transferred at a rising
// edge where start is high and busy is low. All cells compare their entry with
// the command's value at that edge. In the next cycle busy is high and every
// cell updates at once from its own flags and its neighbors' entries, so
// insert and remove shift the chain in a single step.
// The result is registered at the end of that cycle and shown on o_result
// for exactly one cycle with o_valid high. No new command is taken while busy
// is high; the next one can be taken in the cycle where the previous result
// is shown. The cell chain runs its compare step and then its shift step.
// The receiver cannot stall: each result is taken when shown.
// Reset clears the entry count and the sequencer; entries stay as they are and
// are read only below the count. Insert into a full table reports full.
module sorted_value_table
    import svt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_cmd,
    output logic    o_valid,
    output t_result o_result
);

    t_state           r_state;
    t_state           n_state;
    logic [1:0]       r_kind;
    logic [KEY_W-1:0] r_key;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_valid;
    logic             n_valid;
    t_result          r_result;
    t_result          n_result;
    t_cell_ctl        cell_ctl;
    logic [KEY_W-1:0] cell_key;
    logic             accept;
    logic             found;
    logic             full;

    logic [DEPTH-1:0] lt;
    logic [DEPTH-1:0] hit;
    logic [KEY_W-1:0] entry [DEPTH];

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state == ST_APPLY);
    assign found  = |hit;
    assign full   = (r_count == CNT_W'(DEPTH));
    assign cell_key = (r_state == ST_IDLE) ? (i_cmd.value ^ SIGN_FLIP) : r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        if (accept) begin
            r_kind <= i_cmd.kind;
            r_key  <= i_cmd.value ^ SIGN_FLIP;
        end
        r_result <= n_result;
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_valid       = 1'b0;
        n_result      = r_result;
        cell_ctl.load = accept;
        cell_ctl.ins  = 1'b0;
        cell_ctl.rem  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                n_state         = ST_IDLE;
                n_valid         = 1'b1;
                n_result.status = STAT_DONE;
                unique case (r_kind)
                    KIND_INSERT: begin
                        if (full) begin
                            n_result.status = STAT_FULL;
                        end else begin
                            cell_ctl.ins = 1'b1;
                            n_count      = r_count + CNT_W'(1);
                        end
                    end
                    KIND_REMOVE: begin
                        if (found) begin
                            cell_ctl.rem = 1'b1;
                            n_count      = r_count - CNT_W'(1);
                        end else begin
                            n_result.status = STAT_NOT_FOUND;
                        end
                    end
                    KIND_FIND: begin
                        if (!found) begin
                            n_result.status = STAT_NOT_FOUND;
                        end
                    end
                    KIND_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                        n_count = r_count;
                    end
                endcase
                n_result.count = 5'(n_count);
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic             prev_lt;
        logic [KEY_W-1:0] prev_entry;
        logic [KEY_W-1:0] next_entry;
        logic             occ;

        assign occ = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_first
            assign prev_lt    = 1'b1;
            assign prev_entry = '0;
        end else begin : g_mid
            assign prev_lt    = lt[g-1];
            assign prev_entry = entry[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign next_entry = '0;
        end else begin : g_inner
            assign next_entry = entry[g+1];
        end

        svt_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_occ        (occ),
            .i_key        (cell_key),
            .i_prev_lt    (prev_lt),
            .i_prev_entry (prev_entry),
            .i_next_entry (next_entry),
            .o_lt         (lt[g]),
            .o_hit        (hit[g]),
            .o_entry      (entry[g])
        );
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
